FILE: rtl/rtwa_pkg.sv
// Shared types and constants of the route table with aging unit.
// Holds the item kind codes, update status codes, register indexes and table entry layout.
// Depends on nothing.
package rtwa_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int ADDR_W  = 48;
    localparam int HOPS_W  = 8;
    localparam int STAMP_W = 32;
    localparam int COUNT_W = 6;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;

    localparam logic [HOPS_W-1:0]  HOP_LIMIT_RST = 8'd16;
    localparam logic [STAMP_W-1:0] TIMEOUT_RST   = 32'd30000;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 6'd63;

    typedef enum logic [1:0] {
        KIND_UPDATE = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_EXPIRE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_IMPROVED  = 3'd1,
        ST_REFRESHED = 3'd2,
        ST_UNCHANGED = 3'd3,
        ST_FULL      = 3'd4,
        ST_DROPPED   = 3'd5
    } upd_status_t;

    // Register select bit: paddr[2]
    localparam logic REG_HOP_LIMIT = 1'b0;
    localparam logic REG_TIMEOUT   = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0]  dest;
        logic [ADDR_W-1:0]  via;
        logic [HOPS_W-1:0]  hops;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

endpackage

FILE: rtl/route_table_with_aging_unit.sv
// Route table with aging: top level, single module with its sequencer and entry memory.
// Depends on rtwa_pkg for types, codes and table size.
//
// Each transaction takes a sequential scan of the table through one memory read port
// and one shared compare unit (48-bit address match, 32-bit wrapped age subtract and
// compare). An update or lookup whose destination hits stops at the hit; otherwise the
// scan visits all TABLE_ENTRIES slots, one per cycle. A transaction passes through
// accept, read issue lag, scan, write-back (updates) and result load; a dropped update
// or an unknown kind goes from accept straight to result load. s_ready is high only
// between transactions; a finished result waits in the output register, so the next
// transaction may be accepted before it is taken. Valid bits sit in flip-flops cleared
// at reset; entry fields live in the memory and are only read behind a set valid bit,
// so no clearing pass is needed. The user is to write configuration over the APB port
// only while idle, unchecked by the block: hop limit at byte 0, route timeout at byte 4.
module route_table_with_aging_unit (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_kind,
    input  logic [rtwa_pkg::ADDR_W-1:0]       s_dest_addr,
    input  logic [rtwa_pkg::ADDR_W-1:0]       s_via_addr,
    input  logic [rtwa_pkg::HOPS_W-1:0]       s_hops,
    input  logic [rtwa_pkg::STAMP_W-1:0]      s_time_ms,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_found,
    output logic [rtwa_pkg::ADDR_W-1:0]       m_next_hop_out,
    output logic [2:0]                        m_update_status,
    output logic [rtwa_pkg::COUNT_W-1:0]      m_expired_count,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtwa_pkg::CFG_AW-1:0]       paddr,
    input  logic [rtwa_pkg::CFG_DW-1:0]       pwdata,
    output logic [rtwa_pkg::CFG_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int N     = rtwa_pkg::TABLE_ENTRIES;
    localparam int IW    = rtwa_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t                            state_reg, state_next;
    logic [IW-1:0]                     scan_idx_reg, scan_idx_next;
    logic                              issue_reg, issue_next;
    logic                              cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]                     cmp_idx_reg, cmp_idx_next;

    // Latched transaction payload
    rtwa_pkg::kind_t                   kind_reg, kind_next;
    logic [rtwa_pkg::ADDR_W-1:0]       dest_reg, dest_next;
    logic [rtwa_pkg::ADDR_W-1:0]       via_reg, via_next;
    logic [rtwa_pkg::HOPS_W-1:0]       hops_reg, hops_next;
    logic [rtwa_pkg::STAMP_W-1:0]      now_reg, now_next;

    // Scan findings
    logic                              hit_reg, hit_next;
    logic [IW-1:0]                     hit_idx_reg, hit_idx_next;
    logic [rtwa_pkg::HOPS_W-1:0]       hit_hops_reg, hit_hops_next;
    logic [rtwa_pkg::ADDR_W-1:0]       hit_via_reg, hit_via_next;
    logic                              free_reg, free_next;
    logic [IW-1:0]                     free_idx_reg, free_idx_next;

    // Result under construction
    logic                              res_found_reg, res_found_next;
    logic [rtwa_pkg::ADDR_W-1:0]       res_nh_reg, res_nh_next;
    rtwa_pkg::upd_status_t             res_status_reg, res_status_next;
    logic [rtwa_pkg::COUNT_W-1:0]      res_count_reg, res_count_next;

    // Output register
    logic                              m_valid_reg, m_valid_next;
    logic                              m_found_reg, m_found_next;
    logic [rtwa_pkg::ADDR_W-1:0]       m_nh_reg, m_nh_next;
    logic [2:0]                        m_status_reg, m_status_next;
    logic [rtwa_pkg::COUNT_W-1:0]      m_count_reg, m_count_next;

    // Table state and configuration
    logic [N-1:0]                      entry_valid_reg, entry_valid_next;
    logic [rtwa_pkg::HOPS_W-1:0]       hop_limit_reg, hop_limit_next;
    logic [rtwa_pkg::STAMP_W-1:0]      timeout_reg, timeout_next;

    // Entry memory: one read port (registered data), one write port
    rtwa_pkg::entry_t                  entry_mem [N];
    rtwa_pkg::entry_t                  mem_q_reg;
    logic                              rd_en;
    logic [IW-1:0]                     rd_addr;
    logic                              wr_en;
    logic [IW-1:0]                     wr_addr;
    rtwa_pkg::entry_t                  wr_data;

    // Shared compare unit
    logic                              cur_valid;
    logic                              addr_match;
    logic [rtwa_pkg::STAMP_W-1:0]      age;
    logic                              aged_out;
    logic                              cfg_wr;
    logic                              wr_insert;

    assign cur_valid  = entry_valid_reg[cmp_idx_reg];
    assign addr_match = (mem_q_reg.dest == dest_reg);
    assign age        = now_reg - mem_q_reg.stamp;
    assign aged_out   = (age > timeout_reg);

    assign cfg_wr = psel && penable && pwrite;

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_next_hop_out  = m_nh_reg;
    assign m_update_status = m_status_reg;
    assign m_expired_count = m_count_reg;
    assign pready          = 1'b1;

    always_comb begin
        unique case (paddr[2])
            rtwa_pkg::REG_HOP_LIMIT: prdata = rtwa_pkg::CFG_DW'(hop_limit_reg);
            rtwa_pkg::REG_TIMEOUT:   prdata = timeout_reg;
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        state_next       = state_reg;
        scan_idx_next    = scan_idx_reg;
        issue_next       = issue_reg;
        cmp_vld_next     = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        kind_next        = kind_reg;
        dest_next        = dest_reg;
        via_next         = via_reg;
        hops_next        = hops_reg;
        now_next         = now_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        hit_hops_next    = hit_hops_reg;
        hit_via_next     = hit_via_reg;
        free_next        = free_reg;
        free_idx_next    = free_idx_reg;
        res_found_next   = res_found_reg;
        res_nh_next      = res_nh_reg;
        res_status_next  = res_status_reg;
        res_count_next   = res_count_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_found_next     = m_found_reg;
        m_nh_next        = m_nh_reg;
        m_status_next    = m_status_reg;
        m_count_next     = m_count_reg;
        entry_valid_next = entry_valid_reg;
        hop_limit_next   = hop_limit_reg;
        timeout_next     = timeout_reg;
        rd_en            = 1'b0;
        rd_addr          = scan_idx_reg;
        wr_en            = 1'b0;
        wr_addr          = hit_idx_reg;
        wr_data          = '{dest: dest_reg, via: via_reg, hops: hops_reg, stamp: now_reg};
        wr_insert        = 1'b0;

        // Configuration writes are to arrive only while idle; the block does not enforce it
        if (cfg_wr) begin
            unique case (paddr[2])
                rtwa_pkg::REG_HOP_LIMIT: hop_limit_next = pwdata[rtwa_pkg::HOPS_W-1:0];
                rtwa_pkg::REG_TIMEOUT:   timeout_next   = pwdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next       = rtwa_pkg::kind_t'(s_kind);
                    dest_next       = s_dest_addr;
                    via_next        = s_via_addr;
                    hops_next       = s_hops;
                    now_next        = s_time_ms;
                    scan_idx_next   = '0;
                    issue_next      = 1'b1;
                    hit_next        = 1'b0;
                    free_next       = 1'b0;
                    res_found_next  = 1'b0;
                    res_nh_next     = '0;
                    res_status_next = rtwa_pkg::ST_INSERTED;
                    res_count_next  = '0;
                    priority if (s_kind == rtwa_pkg::KIND_UPDATE && s_hops >= hop_limit_reg)
                    begin
                        res_status_next = rtwa_pkg::ST_DROPPED;
                        state_next      = S_DONE;
                    end else if (s_kind == rtwa_pkg::KIND_NONE) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Issue one read a cycle; the compare runs in the cycle after its read is issued
                if (issue_reg) begin
                    rd_en        = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_idx_reg;
                    if (scan_idx_reg == LAST_IDX) begin
                        issue_next = 1'b0;
                    end else begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end

                if (cmp_vld_reg) begin
                    unique case (kind_reg)
                        rtwa_pkg::KIND_LOOKUP: begin
                            if (cur_valid && addr_match) begin
                                res_found_next = 1'b1;
                                res_nh_next    = mem_q_reg.via;
                                cmp_vld_next   = 1'b0;
                                state_next     = S_DONE;
                            end else if (cmp_idx_reg == LAST_IDX) begin
                                state_next = S_DONE;
                            end
                        end
                        rtwa_pkg::KIND_UPDATE: begin
                            if (cur_valid && addr_match) begin
                                hit_next      = 1'b1;
                                hit_idx_next  = cmp_idx_reg;
                                hit_hops_next = mem_q_reg.hops;
                                hit_via_next  = mem_q_reg.via;
                                cmp_vld_next  = 1'b0;
                                state_next    = S_WRITE;
                            end else begin
                                // Remember the lowest free slot for a later insert
                                if (!cur_valid && !free_reg) begin
                                    free_next     = 1'b1;
                                    free_idx_next = cmp_idx_reg;
                                end
                                if (cmp_idx_reg == LAST_IDX) begin
                                    state_next = S_WRITE;
                                end
                            end
                        end
                        rtwa_pkg::KIND_EXPIRE: begin
                            if (cur_valid && aged_out) begin
                                entry_valid_next[cmp_idx_reg] = 1'b0;
                                if (res_count_reg != rtwa_pkg::COUNT_MAX) begin
                                    res_count_next = res_count_reg + 1'b1;
                                end
                            end
                            if (cmp_idx_reg == LAST_IDX) begin
                                state_next = S_DONE;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_WRITE: begin
                priority if (hit_reg) begin
                    // Improved and refreshed both leave the whole word as offered
                    if (hops_reg < hit_hops_reg) begin
                        wr_en           = 1'b1;
                        res_status_next = rtwa_pkg::ST_IMPROVED;
                    end else if (hops_reg == hit_hops_reg && via_reg == hit_via_reg) begin
                        wr_en           = 1'b1;
                        res_status_next = rtwa_pkg::ST_REFRESHED;
                    end else begin
                        res_status_next = rtwa_pkg::ST_UNCHANGED;
                    end
                end else if (free_reg) begin
                    wr_en                          = 1'b1;
                    wr_addr                        = free_idx_reg;
                    wr_insert                      = 1'b1;
                    entry_valid_next[free_idx_reg] = 1'b1;
                    res_status_next                = rtwa_pkg::ST_INSERTED;
                end else begin
                    res_status_next = rtwa_pkg::ST_FULL;
                end
                state_next = S_DONE;
            end

            S_DONE: begin
                // Hand over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = res_found_reg;
                    m_nh_next     = res_nh_reg;
                    m_status_next = res_status_reg;
                    m_count_next  = res_count_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            issue_reg       <= 1'b0;
            cmp_vld_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            entry_valid_reg <= '0;
            hop_limit_reg   <= rtwa_pkg::HOP_LIMIT_RST;
            timeout_reg     <= rtwa_pkg::TIMEOUT_RST;
            res_count_reg   <= '0;
        end else begin
            state_reg       <= state_next;
            issue_reg       <= issue_next;
            cmp_vld_reg     <= cmp_vld_next;
            m_valid_reg     <= m_valid_next;
            entry_valid_reg <= entry_valid_next;
            hop_limit_reg   <= hop_limit_next;
            timeout_reg     <= timeout_next;
            res_count_reg   <= res_count_next;
        end
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        kind_reg       <= kind_next;
        dest_reg       <= dest_next;
        via_reg        <= via_next;
        hops_reg       <= hops_next;
        now_reg        <= now_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_hops_reg   <= hit_hops_next;
        hit_via_reg    <= hit_via_next;
        free_reg       <= free_next;
        free_idx_reg   <= free_idx_next;
        res_found_reg  <= res_found_next;
        res_nh_reg     <= res_nh_next;
        res_status_reg <= res_status_next;
        m_found_reg    <= m_found_next;
        m_nh_reg       <= m_nh_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
    end

    // Entry memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= entry_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_count_reg <= rtwa_pkg::COUNT_W'(N))
        else $error("expire count exceeds table size");

    a_insert_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_insert |=> entry_valid_reg[$past(free_idx_reg)])
        else $error("inserted slot not marked valid");

    a_compare_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> state_reg == S_SCAN)
        else $error("compare stage active outside scan");

    a_found_fields_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |->
            (m_update_status == rtwa_pkg::ST_INSERTED && m_expired_count == '0))
        else $error("lookup hit carries update or expire fields");

endmodule
